@@ hw/rtl/sorted_priority_queue_macros.svh @@
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPQ_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SPQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef struct packed {
      logic load;
      logic push;
      logic pop;
   } cmd_type;

   // a <= b ordering on (priority, value), signed
   function automatic logic pair_le(data_type pa, data_type va, data_type pb, data_type vb);
      logic r;
      if (pa != pb) begin
         r = (pa < pb);
      end else begin
         r = (va <= vb);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output      logic            req_tready,
   input  wire logic            req_tuser,
   output      logic            rsp_tvalid,
   input  wire logic            rsp_tready,
   output      spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;

   // output slot is free when empty or being drained this cycle
   assign req_tready = (state_ff == S_IDLE) || rsp_tready;
   assign rsp_tvalid = (state_ff == S_HOLD);

   always_comb begin
      cmd.load = req_tvalid && req_tready;
      cmd.push = cmd.load && (mode_type'(req_tuser) == MODE_PUSH);
      cmd.pop  = cmd.load && (mode_type'(req_tuser) == MODE_POP);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (cmd.load) begin
               state_in = S_HOLD;
            end else if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/spq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module spq_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spq_pkg::cmd_type                  cmd,
   input  wire spq_pkg::data_type                 entry_priority,
   input  wire spq_pkg::data_type                 entry_value,
   output      logic [spq_pkg::STATUS_W-1:0]      status,
   output      logic                              head_valid,
   output      spq_pkg::data_type                 head_priority,
   output      spq_pkg::data_type                 head_value,
   output      logic [spq_pkg::OCC_W-1:0]         occupancy
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   data_type slot_pri_ff [CAPACITY];
   data_type slot_val_ff [CAPACITY];
   data_type slot_pri_in [CAPACITY];
   data_type slot_val_in [CAPACITY];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   status_type status_ff;
   status_type status_in;
   logic [CAPACITY-1:0] le;
   logic is_full;
   logic is_empty;
   logic do_push;
   logic do_pop;
   logic [31:0] count_wide;

   assign is_full  = (count_ff == CAP_CNT);
   assign is_empty = (count_ff == '0);
   assign do_push  = cmd.push && !is_full;
   assign do_pop   = cmd.pop && !is_empty;

   // le is a prefix of ones over the occupied cells: insert point is its end
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      assign le[i] = (IDX < count_ff) &&
                     pair_le(slot_pri_ff[i], slot_val_ff[i], entry_priority, entry_value);

      always_comb begin
         slot_pri_in[i] = slot_pri_ff[i];
         slot_val_in[i] = slot_val_ff[i];
         if (do_push) begin
            if (!le[i]) begin
               if (i == 0) begin
                  slot_pri_in[i] = entry_priority;
                  slot_val_in[i] = entry_value;
               end else if (le[(i == 0) ? 0 : i-1]) begin
                  slot_pri_in[i] = entry_priority;
                  slot_val_in[i] = entry_value;
               end else begin
                  slot_pri_in[i] = slot_pri_ff[(i == 0) ? 0 : i-1];
                  slot_val_in[i] = slot_val_ff[(i == 0) ? 0 : i-1];
               end
            end
         end else if (do_pop && (i < CAPACITY-1)) begin
            slot_pri_in[i] = slot_pri_ff[(i < CAPACITY-1) ? i+1 : i];
            slot_val_in[i] = slot_val_ff[(i < CAPACITY-1) ? i+1 : i];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.load) begin
         status_in = ST_OK;
         if (cmd.push && is_full) begin
            status_in = ST_FULL;
         end
         if (cmd.pop && is_empty) begin
            status_in = ST_EMPTY;
         end
      end
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      for (int k = 0; k < CAPACITY; k++) begin
         slot_pri_ff[k] <= slot_pri_in[k];
         slot_val_ff[k] <= slot_val_in[k];
      end
   end

   // result is read straight from the state: it only changes as a new item loads or on reset
   assign count_wide    = 32'(count_ff);
   assign status        = status_ff;
   assign head_valid    = !is_empty;
   assign head_priority = is_empty ? '0 : slot_pri_ff[0];
   assign head_value    = is_empty ? '0 : slot_val_ff[0];
   assign occupancy     = count_wide[OCC_W-1:0];

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CAP_CNT, "count above capacity")
   `SPQ_ASSERT_NEXT(a_push_grows, do_push, count_ff == $past(count_ff) + CW'(1), "push lost")
   `SPQ_ASSERT_NEXT(a_pop_shrinks, do_pop, count_ff == $past(count_ff) - CW'(1), "pop lost")
   `SPQ_ASSERT_NEXT(a_full_holds, cmd.push && is_full,
                    $stable(count_ff) && (status_ff == ST_FULL), "full push changed state")
   `SPQ_ASSERT_NOW(a_head_order, count_ff >= CW'(2),
                   pair_le(slot_pri_ff[0], slot_val_ff[0], slot_pri_ff[1], slot_val_ff[1]),
                   "head out of order")

endmodule

`default_nettype wire

@@ hw/rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                  Payload
// req      in   req_tvalid/tready      tuser: mode; tdata: entry_priority, entry_value
// rsp      out  rsp_tvalid/tready      tdata: status, head_valid, head_priority,
//                                             head_value, occupancy
//
// One item per cycle while rsp is not stalled: a push or pop updates the sorted
// cell array in the cycle it is accepted, its result is shown from the next cycle on.
// A new item is taken in the same cycle the pending result is taken.
// Synchronous active-high reset empties the queue; cell contents are not cleared.
// rsp stall holds req_tready low once a result is pending.

module sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,   // entry_priority[31:0], entry_value[63:32]
   input  wire logic        req_tuser,   // mode[0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [71:0] rsp_tdata    // status[1:0], head_valid[2], head_priority[34:3],
                                         // head_value[66:35], occupancy[71:67]
);
   import spq_pkg::*;

   cmd_type cmd;
   logic [STATUS_W-1:0] status;
   logic head_valid;
   data_type head_priority;
   data_type head_value;
   logic [OCC_W-1:0] occupancy;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .entry_priority (req_tdata[31:0]),
      .entry_value    (req_tdata[63:32]),
      .status         (status),
      .head_valid     (head_valid),
      .head_priority  (head_priority),
      .head_value     (head_value),
      .occupancy      (occupancy)
   );

   assign rsp_tdata = {occupancy, head_value, head_priority, head_valid, status};

endmodule

`default_nettype wire

@@ bench/tb_sorted_priority_queue.sv @@
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int RAND_ITEMS  = 1330;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      status_type  status;
      logic        head_valid;
      data_type    head_priority;
      data_type    head_value;
      logic [4:0]  occupancy;
   } head_report_type;

   class pq_scoreboard;
      data_type        slot_pri[CAPACITY];
      data_type        slot_val[CAPACITY];
      int              held;
      head_report_type pending[$];
      int              errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function int waiting();
         return pending.size();
      endfunction

      // new pair goes ahead of the first entry that is strictly greater
      function void note_item(mode_type m, data_type p, data_type v);
         head_report_type r;
         int              pos;
         r.status = ST_OK;
         if (m == MODE_PUSH) begin
            if (held >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < held && !(p < slot_pri[pos] ||
                      (p == slot_pri[pos] && v < slot_val[pos]))) begin
                  pos++;
               end
               for (int i = held; i > pos; i--) begin
                  slot_pri[i] = slot_pri[i-1];
                  slot_val[i] = slot_val[i-1];
               end
               slot_pri[pos] = p;
               slot_val[pos] = v;
               held++;
            end
         end else begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (int i = 1; i < held; i++) begin
                  slot_pri[i-1] = slot_pri[i];
                  slot_val[i-1] = slot_val[i];
               end
               held--;
            end
         end
         r.head_valid    = (held > 0);
         r.head_priority = (held > 0) ? slot_pri[0] : '0;
         r.head_value    = (held > 0) ? slot_val[0] : '0;
         r.occupancy     = held[4:0];
         pending.push_back(r);
      endfunction

      function void compare(string field, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t ns: %s expected %0d actual %0d", $time, field, e, a);
         end
      endfunction

      function void check_result(logic [71:0] word);
         head_report_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result item %h", $time, word);
            return;
         end
         e = pending.pop_front();
         compare("status", e.status, word[1:0]);
         compare("head_valid", e.head_valid, word[2]);
         compare("head_priority", e.head_priority, $signed(word[34:3]));
         compare("head_value", e.head_value, $signed(word[66:35]));
         compare("occupancy", e.occupancy, word[71:67]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   pq_scoreboard sb = new();
   bit           no_idle = 1'b0;
   int           quiet_cycles = 0;

   sorted_priority_queue #(.CAPACITY(CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int gap_draw();
      if (no_idle) begin
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // mix of full-range, near-zero and extreme values so ties are common
   function automatic data_type pick_field();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 6)) - 3;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sh0000_0000;
               default: return 32'shffff_ffff;
            endcase
         end
         default: return $signed($urandom_range(0, 40)) - 20;
      endcase
   endfunction

   task automatic send_item(input mode_type m, input data_type p, input data_type v);
      int gap;
      gap = gap_draw();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = m;
      req_tdata  = {v, p};
      do @(posedge clock); while (!req_tready);
      sb.note_item(m, p, v);
   endtask

   task automatic drain_results();
      while (sb.waiting() > 0) @(posedge clock);
   endtask

   task automatic receive_results();
      int stall;
      forever begin
         stall = gap_draw();
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int       sent;
      int       phase_len;
      int       push_pct;
      int       phase_no;
      mode_type m;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         receive_results();
      join_none

      // pops on empty carry junk fields that must be ignored
      send_item(MODE_POP, 32'shffff_ffff, 32'shffff_ffff);
      send_item(MODE_POP, 32'sh8000_0000, 32'sh7fff_ffff);
      send_item(MODE_PUSH, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_item(MODE_PUSH, 32'sh8000_0000, 32'sh8000_0000);
      send_item(MODE_PUSH, 32'sh8000_0000, 32'sh7fff_ffff);
      send_item(MODE_PUSH, 32'sh7fff_ffff, 32'sh8000_0000);
      send_item(MODE_PUSH, 0, 0);
      send_item(MODE_PUSH, 0, 0);
      send_item(MODE_PUSH, -1, -1);
      send_item(MODE_PUSH, 0, -1);
      send_item(MODE_PUSH, -1, 0);
      send_item(MODE_PUSH, 5, 5);
      send_item(MODE_PUSH, 5, 5);
      send_item(MODE_PUSH, 5, 4);
      send_item(MODE_PUSH, 4, 5);
      send_item(MODE_PUSH, 1, 1);
      send_item(MODE_PUSH, 2, 2);
      send_item(MODE_PUSH, 3, 3);
      // queue full: dropped
      send_item(MODE_PUSH, 32'sh8000_0000, 32'sh8000_0000);
      repeat (4) send_item(MODE_POP, pick_field(), pick_field());

      sent     = 0;
      phase_no = 0;
      while (sent < RAND_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: push_pct = 80;
            1: push_pct = 20;
            default: push_pct = 50;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase_no == 6 || $urandom_range(0, 7) == 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            drain_results();
         end
         for (int i = 0; i < phase_len && sent < RAND_ITEMS; i++) begin
            m = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
            send_item(m, pick_field(), pick_field());
            sent++;
         end
         phase_no++;
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      no_idle = 1'b0;
      drain_results();
      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.waiting() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
